// ===== sv/cht_pkg.sv =====
// Shared types, sizes and codes for the chained hash table.
// Used by every module of the block; depends on nothing.
package cht_pkg;

    localparam int MAX_BUCKETS = 64;
    localparam int POOL_NODES  = 256;

    localparam int KEY_W   = 31;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 2;
    localparam int CFG_W   = 7;
    localparam int BKT_W   = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int IDX_W   = $clog2(POOL_NODES);
    localparam int PTR_W   = IDX_W + 1;
    localparam int CNT_W   = PTR_W;
    localparam int RANK_W  = 9;
    localparam int STEP_W  = $clog2(KEY_W);

    localparam int IN_TDATA_W  = ((CMD_W + KEY_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((STAT_W + RANK_W + 7) / 8) * 8;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

    localparam logic [STAT_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

    localparam logic [PTR_W-1:0] NIL = PTR_W'(POOL_NODES);

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [KEY_W-1:0] key;
        logic [BKT_W-1:0] bucket;
    } job_t;

endpackage

// ===== sv/cht_front.sv =====
// Front end of the chained hash table: accepts input beats and computes the
// bucket (key modulo bucket count) one key bit per cycle. Uses cht_pkg.
module cht_front
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [cht_pkg::CFG_W-1:0]   bucket_count,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [cht_pkg::CMD_W-1:0]   in_cmd,
    input  logic [cht_pkg::KEY_W-1:0]   in_key,
    output logic                        push_valid,
    input  logic                        push_ready,
    output cht_pkg::job_t               push_job
);

    typedef enum logic [2:0]
    {
        F_IDLE = 3'b001,
        F_DIV  = 3'b010,
        F_PUSH = 3'b100
    } fstate_t;

    fstate_t                        state_reg, state_next;
    logic [cht_pkg::CMD_W-1:0]      cmd_reg;
    logic [cht_pkg::KEY_W-1:0]      key_reg;
    logic [cht_pkg::CFG_W-1:0]      rem_reg, rem_next;
    logic [cht_pkg::STEP_W-1:0]     step_reg, step_next;
    logic [cht_pkg::CFG_W-1:0]      modulus;
    logic [cht_pkg::CFG_W:0]        trial;

    // A zero count acts as one bucket, a count above the table as the full table.
    always_comb
    begin
        if (bucket_count == '0)
            modulus = cht_pkg::CFG_W'(1);
        else if (32'(bucket_count) > cht_pkg::MAX_BUCKETS)
            modulus = cht_pkg::CFG_W'(cht_pkg::MAX_BUCKETS);
        else
            modulus = bucket_count;
    end

    assign trial = {rem_reg, key_reg[step_reg]};

    always_comb
    begin
        state_next = state_reg;
        rem_next   = rem_reg;
        step_next  = step_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = F_DIV;
                    rem_next   = '0;
                    step_next  = cht_pkg::STEP_W'(cht_pkg::KEY_W - 1);
                end
            end
            F_DIV:
            begin
                if (trial >= {1'b0, modulus})
                    rem_next = cht_pkg::CFG_W'(trial - {1'b0, modulus});
                else
                    rem_next = cht_pkg::CFG_W'(trial);
                if (step_reg == '0)
                    state_next = F_PUSH;
                else
                    step_next = step_reg - 1'b1;
            end
            F_PUSH:
            begin
                if (push_ready)
                    state_next = F_IDLE;
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= F_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        step_reg <= step_next;
        if (state_reg == F_IDLE && in_valid)
        begin
            cmd_reg <= in_cmd;
            key_reg <= in_key;
        end
    end

    assign in_ready        = (state_reg == F_IDLE);
    assign push_valid      = (state_reg == F_PUSH);
    assign push_job.cmd    = cmd_reg;
    assign push_job.key    = key_reg;
    assign push_job.bucket = cht_pkg::BKT_W'(rem_reg);

endmodule

// ===== sv/cht_queue.sv =====
// Two-entry job queue between the front end and the back end.
// Uses cht_pkg for the job type.
module cht_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_valid,
    output logic            wr_ready,
    input  cht_pkg::job_t   wr_job,
    output logic            rd_valid,
    input  logic            rd_ready,
    output cht_pkg::job_t   rd_job
);

    cht_pkg::job_t  slot_reg [2];
    logic           wr_ptr_reg, rd_ptr_reg;
    logic [1:0]     count_reg;
    logic           do_wr, do_rd;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_job   = slot_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (do_rd)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (do_wr && !do_rd)
                count_reg <= count_reg + 2'd1;
            else if (do_rd && !do_wr)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_job;
    end

endmodule

// ===== sv/cht_back.sv =====
// Back end of the chained hash table: owns the bucket heads, node pool and free
// stack, runs insert, search and delete, and holds the result register. Uses cht_pkg.
module cht_back
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            job_valid,
    output logic                            job_ready,
    input  cht_pkg::job_t                   job,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [cht_pkg::STAT_W-1:0]      out_status,
    output logic [cht_pkg::RANK_W-1:0]      out_rank
);

    typedef enum logic [4:0]
    {
        B_IDLE  = 5'b00001,
        B_HEAD  = 5'b00010,
        B_WALK  = 5'b00100,
        B_CHECK = 5'b01000,
        B_DONE  = 5'b10000
    } bstate_t;

    bstate_t                            state_reg, state_next;
    cht_pkg::job_t                      job_reg;
    logic [cht_pkg::PTR_W-1:0]          cur_reg, cur_next;
    logic [cht_pkg::PTR_W-1:0]          prev_reg, prev_next;
    logic [cht_pkg::RANK_W-1:0]         rank_reg, rank_next;
    logic [cht_pkg::CNT_W-1:0]          free_cnt_reg, free_cnt_next;
    logic [cht_pkg::STAT_W-1:0]         res_status_reg, res_status_next;
    logic [cht_pkg::RANK_W-1:0]         res_rank_reg, res_rank_next;
    logic                               out_valid_reg;
    logic [cht_pkg::STAT_W-1:0]         out_status_reg;
    logic [cht_pkg::RANK_W-1:0]         out_rank_reg;

    // Bucket heads, with a valid bit per entry so that reset empties every chain.
    logic [cht_pkg::PTR_W-1:0]          head_mem [cht_pkg::MAX_BUCKETS];
    logic [cht_pkg::MAX_BUCKETS-1:0]    head_vld_reg;
    logic [cht_pkg::PTR_W-1:0]          head_q_reg;
    logic                               head_qv_reg;
    logic [cht_pkg::BKT_W-1:0]          head_raddr, head_waddr;
    logic                               head_we;
    logic [cht_pkg::PTR_W-1:0]          head_wdata;

    // Node pool.
    logic [cht_pkg::KEY_W-1:0]          key_mem  [cht_pkg::POOL_NODES];
    logic [cht_pkg::PTR_W-1:0]          next_mem [cht_pkg::POOL_NODES];
    logic [cht_pkg::KEY_W-1:0]          key_q_reg;
    logic [cht_pkg::PTR_W-1:0]          next_q_reg;
    logic [cht_pkg::IDX_W-1:0]          node_raddr;
    logic                               key_we, next_we;
    logic [cht_pkg::IDX_W-1:0]          key_waddr, next_waddr;
    logic [cht_pkg::PTR_W-1:0]          next_wdata;

    // Free stack; an entry never written holds its own index.
    logic [cht_pkg::IDX_W-1:0]          fs_mem [cht_pkg::POOL_NODES];
    logic [cht_pkg::POOL_NODES-1:0]     fs_vld_reg;
    logic [cht_pkg::IDX_W-1:0]          fs_q_reg;
    logic                               fs_qv_reg;
    logic [cht_pkg::IDX_W-1:0]          fs_raddr, fs_raddr_q_reg, fs_waddr;
    logic                               fs_we;

    logic [cht_pkg::PTR_W-1:0]          head_ptr;
    logic [cht_pkg::IDX_W-1:0]          alloc_node;
    logic                               walk_end;

    assign head_ptr   = head_qv_reg ? head_q_reg : cht_pkg::NIL;
    assign alloc_node = fs_qv_reg ? fs_q_reg : fs_raddr_q_reg;
    assign walk_end   = cur_reg[cht_pkg::PTR_W-1]
                        || (rank_reg == cht_pkg::RANK_W'(cht_pkg::POOL_NODES));

    assign head_raddr = job.bucket;
    assign fs_raddr   = cht_pkg::IDX_W'(free_cnt_reg - 1'b1);
    assign node_raddr = cur_reg[cht_pkg::IDX_W-1:0];
    assign fs_waddr   = cht_pkg::IDX_W'(free_cnt_reg);

    always_comb
    begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        rank_next       = rank_reg;
        free_cnt_next   = free_cnt_reg;
        res_status_next = res_status_reg;
        res_rank_next   = res_rank_reg;
        head_we         = 1'b0;
        head_waddr      = job_reg.bucket;
        head_wdata      = cur_reg;
        key_we          = 1'b0;
        key_waddr       = alloc_node;
        next_we         = 1'b0;
        next_waddr      = alloc_node;
        next_wdata      = head_ptr;
        fs_we           = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                if (job_valid)
                    state_next = B_HEAD;
            end
            B_HEAD:
            begin
                res_rank_next = '0;
                state_next    = B_DONE;
                if (job_reg.cmd == cht_pkg::CMD_INSERT)
                begin
                    if (free_cnt_reg == '0)
                        res_status_next = cht_pkg::ST_FULL;
                    else
                    begin
                        key_we          = 1'b1;
                        next_we         = 1'b1;
                        head_we         = 1'b1;
                        head_wdata      = {1'b0, alloc_node};
                        free_cnt_next   = free_cnt_reg - 1'b1;
                        res_status_next = cht_pkg::ST_DONE;
                    end
                end
                else if (job_reg.cmd == cht_pkg::CMD_SEARCH
                         || job_reg.cmd == cht_pkg::CMD_DELETE)
                begin
                    cur_next   = head_ptr;
                    prev_next  = cht_pkg::NIL;
                    rank_next  = '0;
                    state_next = B_WALK;
                end
                else
                    res_status_next = cht_pkg::ST_NOT_FOUND;
            end
            B_WALK:
            begin
                if (walk_end)
                begin
                    res_status_next = cht_pkg::ST_NOT_FOUND;
                    res_rank_next   = '0;
                    state_next      = B_DONE;
                end
                else
                begin
                    rank_next  = rank_reg + 1'b1;
                    state_next = B_CHECK;
                end
            end
            B_CHECK:
            begin
                if (key_q_reg == job_reg.key)
                begin
                    res_status_next = cht_pkg::ST_DONE;
                    res_rank_next   = rank_reg;
                    state_next      = B_DONE;
                    if (job_reg.cmd == cht_pkg::CMD_DELETE)
                    begin
                        // Unlink: the predecessor, or the bucket head, skips this node.
                        if (prev_reg[cht_pkg::PTR_W-1])
                        begin
                            head_we    = 1'b1;
                            head_wdata = next_q_reg;
                        end
                        else
                        begin
                            next_we    = 1'b1;
                            next_waddr = prev_reg[cht_pkg::IDX_W-1:0];
                            next_wdata = next_q_reg;
                        end
                        if (32'(free_cnt_reg) < cht_pkg::POOL_NODES)
                        begin
                            fs_we         = 1'b1;
                            free_cnt_next = free_cnt_reg + 1'b1;
                        end
                    end
                end
                else
                begin
                    prev_next  = cur_reg;
                    cur_next   = next_q_reg;
                    state_next = B_WALK;
                end
            end
            B_DONE:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            free_cnt_reg  <= cht_pkg::CNT_W'(cht_pkg::POOL_NODES);
            head_vld_reg  <= '0;
            fs_vld_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            free_cnt_reg <= free_cnt_next;
            if (head_we)
                head_vld_reg[head_waddr] <= 1'b1;
            if (fs_we)
                fs_vld_reg[fs_waddr] <= 1'b1;
            if (state_reg == B_DONE && (!out_valid_reg || out_ready))
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg        <= cur_next;
        prev_reg       <= prev_next;
        rank_reg       <= rank_next;
        res_status_reg <= res_status_next;
        res_rank_reg   <= res_rank_next;
        if (state_reg == B_IDLE && job_valid)
            job_reg <= job;
        if (state_reg == B_DONE && (!out_valid_reg || out_ready))
        begin
            out_status_reg <= res_status_reg;
            out_rank_reg   <= res_rank_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        head_q_reg  <= head_mem[head_raddr];
        head_qv_reg <= head_vld_reg[head_raddr];
        if (head_we)
            head_mem[head_waddr] <= head_wdata;
    end

    always_ff @(posedge clk)
    begin
        key_q_reg  <= key_mem[node_raddr];
        next_q_reg <= next_mem[node_raddr];
        if (key_we)
            key_mem[key_waddr] <= job_reg.key;
        if (next_we)
            next_mem[next_waddr] <= next_wdata;
    end

    always_ff @(posedge clk)
    begin
        fs_q_reg       <= fs_mem[fs_raddr];
        fs_qv_reg      <= fs_vld_reg[fs_raddr];
        fs_raddr_q_reg <= fs_raddr;
        if (fs_we)
            fs_mem[fs_waddr] <= cur_reg[cht_pkg::IDX_W-1:0];
    end

    assign job_ready  = (state_reg == B_IDLE);
    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_rank   = out_rank_reg;

endmodule

// ===== sv/chained_hash_table.sv =====
// Top level of the chained hash table: stream ports, the bucket count register,
// and the front end, job queue and back end from cht_front, cht_queue, cht_back.
//
// This block is a hash table with separate chaining over a pool of 256 nodes and
// up to 64 buckets. Each input beat carries a command (insert, search, delete)
// and a 31-bit key; each beat yields exactly one result beat with a status (done
// or found, not found, pool full) and the 1-based position of the key in its
// chain (zero for inserts and misses). The bucket is the key modulo the bucket
// count register; a count of zero acts as one and a count above 64 as 64. An
// insert links a node from the free stack at the head of its chain, and a delete
// unlinks the first match from the head and returns its node to the free stack.
// The front end takes one beat at a time, computes the modulo one key bit per
// cycle, and accepts no new beat until its job has gone to the queue. The back
// end handles an insert in its head state; a search or delete walks the chain
// node by node, each node passing a walk and a check state around the one
// registered read of the node memory. A two-entry queue between them lets the
// modulo of the next beat overlap the chain walk of the current one; the
// sustained rate is the slower of the two. Results sit in an output register, so
// the back end runs the next job while one waits and stalls only at its result.
// The bucket count should be written only while the block is idle.
module chained_hash_table
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [cht_pkg::CFG_W-1:0]           cfg_data,      // bucket_count
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // command [1:0], key [32:2], zero fill above
    input  logic [cht_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // status [1:0], rank [10:2], zero fill above
    output logic [cht_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

    logic [cht_pkg::CFG_W-1:0]      bucket_count_reg;
    logic                           push_valid, push_ready;
    cht_pkg::job_t                  push_job;
    logic                           pop_valid, pop_ready;
    cht_pkg::job_t                  pop_job;
    logic [cht_pkg::STAT_W-1:0]     res_status;
    logic [cht_pkg::RANK_W-1:0]     res_rank;

    // The register is always ready to take a write.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bucket_count_reg <= cht_pkg::CFG_W'(64);
        else if (cfg_valid)
            bucket_count_reg <= cfg_data;
    end

    cht_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .bucket_count (bucket_count_reg),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .in_cmd       (s_axis_tdata[cht_pkg::CMD_W-1:0]),
        .in_key       (s_axis_tdata[cht_pkg::CMD_W +: cht_pkg::KEY_W]),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_job     (push_job)
    );

    cht_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_job   (push_job),
        .rd_valid (pop_valid),
        .rd_ready (pop_ready),
        .rd_job   (pop_job)
    );

    cht_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (pop_valid),
        .job_ready  (pop_ready),
        .job        (pop_job),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_status (res_status),
        .out_rank   (res_rank)
    );

    assign m_axis_tdata = cht_pkg::OUT_TDATA_W'({res_rank, res_status});

endmodule
